>>> rtl/core/tdrt_pkg.sv
// tdrt_pkg: shared types, constants and tables of the touch dial rotation tracker
// used by every module under rtl/core; depends on nothing else

package tdrt_pkg;

   // default parameter values
   localparam int COORD_BITS_DEF = 10;
   localparam int TOTAL_BITS_DEF = 32;

   // configuration register indexes
   localparam int                CSR_INDEX_W     = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_Y    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_MODE = 2'd2;

   localparam int CENTRE_X_RESET = 160;
   localparam int CENTRE_Y_RESET = 120;

   // result item layout, lowest bit first
   localparam int VALUE_W   = 32;
   localparam int STEP_W    = 9;
   localparam int ANGLE_W   = 9;
   localparam int RSP_FIELDS_W = VALUE_W + STEP_W + ANGLE_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // octant classes handed from front to back
   localparam logic [1:0] KIND_ZERO   = 2'd0;
   localparam logic [1:0] KIND_DIAG   = 2'd1;
   localparam logic [1:0] KIND_CORDIC = 2'd2;

   typedef struct packed {
      logic       touching;
      logic       swapped;
      logic       neg_x;
      logic       neg_y;
      logic [1:0] kind;
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

   // cordic: vector scaled by 2^14, angle in q16 degrees
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_PRESHIFT = 14;
   localparam int FRAC_BITS = 16;
   localparam int ZW = 25;
   localparam int ATAN_W = 22;

   localparam logic [ATAN_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115
   };

   localparam logic signed [ZW-1:0] DEG45_Q  = ZW'(45 * 65536);
   localparam logic signed [ZW-1:0] DEG90_Q  = ZW'(90 * 65536);
   localparam logic signed [ZW-1:0] DEG180_Q = ZW'(180 * 65536);

   localparam int HALF_TURN = 180;
   localparam int FULL_TURN = 360;

   localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/core/tdrt_queue.sv
// tdrt_queue: small register queue between the front and back ends
// depends on tdrt_pkg for its default depth

module tdrt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tdrt_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/core/tdrt_front.sv
// tdrt_front: takes touch samples, forms the offset from the centre and
// folds it to the first octant; depends on tdrt_pkg

module tdrt_front #(
   parameter int COORD_BITS = tdrt_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [COORD_BITS-1:0]     touch_x,
   input  logic [COORD_BITS-1:0]     touch_y,
   input  logic [COORD_BITS-1:0]     centre_x,
   input  logic [COORD_BITS-1:0]     centre_y,
   output logic                      q_push,
   input  logic                      q_full,
   output tdrt_pkg::flags_type       q_flags,
   output logic [COORD_BITS-1:0]     q_big,
   output logic [COORD_BITS-1:0]     q_small
);

   logic                         st_valid_ff, st_valid_in;
   logic [COORD_BITS-1:0]        ax_ff, ay_ff;
   logic                         neg_x_ff, neg_y_ff, touch_ff;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS:0]          abs_x, abs_y;
   logic                         accept, swap;

   assign accept   = in_valid && in_ready;
   assign in_ready = !st_valid_ff || !q_full;
   assign q_push   = st_valid_ff;

   assign dx    = $signed({1'b0, touch_x}) - $signed({1'b0, centre_x});
   assign dy    = $signed({1'b0, touch_y}) - $signed({1'b0, centre_y});
   assign abs_x = dx[COORD_BITS] ? (-dx) : dx;
   assign abs_y = dy[COORD_BITS] ? (-dy) : dy;

   always_comb begin
      st_valid_in = st_valid_ff;
      if (accept) begin
         st_valid_in = 1'b1;
      end else if (st_valid_ff && !q_full) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff    <= abs_x[COORD_BITS-1:0];
         ay_ff    <= abs_y[COORD_BITS-1:0];
         neg_x_ff <= dx[COORD_BITS];
         neg_y_ff <= dy[COORD_BITS];
         touch_ff <= (touch_x != '0) && (touch_y != '0);
      end
   end

   // fold into the first octant and pick the shortcut cases
   assign swap    = ay_ff > ax_ff;
   assign q_big   = swap ? ay_ff : ax_ff;
   assign q_small = swap ? ax_ff : ay_ff;

   always_comb begin
      q_flags.touching = touch_ff;
      q_flags.swapped  = swap;
      q_flags.neg_x    = neg_x_ff;
      q_flags.neg_y    = neg_y_ff;
      priority if (q_small == '0) begin
         q_flags.kind = tdrt_pkg::KIND_ZERO;
      end else if (q_small == q_big) begin
         q_flags.kind = tdrt_pkg::KIND_DIAG;
      end else begin
         q_flags.kind = tdrt_pkg::KIND_CORDIC;
      end
   end

endmodule

>>> rtl/core/tdrt_back.sv
// tdrt_back: cordic angle, unfolding, step and total tracking, result register
// depends on tdrt_pkg

module tdrt_back #(
   parameter int COORD_BITS = tdrt_pkg::COORD_BITS_DEF,
   parameter int TOTAL_BITS = tdrt_pkg::TOTAL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  tdrt_pkg::flags_type                q_flags,
   input  logic [COORD_BITS-1:0]              q_big,
   input  logic [COORD_BITS-1:0]              q_small,
   input  logic                               report_mode,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [tdrt_pkg::RSP_TDATA_W-1:0]   out_data
);

   // room for the cordic gain of about 1.65 on a vector up to sqrt(2) times the
   // larger magnitude, plus the sign
   localparam int CW    = COORD_BITS + tdrt_pkg::CORDIC_PRESHIFT + 3;
   localparam int ZW    = tdrt_pkg::ZW;
   localparam int IW    = $clog2(tdrt_pkg::CORDIC_STEPS);
   localparam int AW    = tdrt_pkg::ANGLE_W;
   localparam int SW    = tdrt_pkg::STEP_W;
   localparam int FB    = tdrt_pkg::FRAC_BITS;
   localparam int PAD_W = tdrt_pkg::RSP_TDATA_W - tdrt_pkg::RSP_FIELDS_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_ANGLE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic signed [AW:0] HALF_S  = (AW + 1)'(tdrt_pkg::HALF_TURN);
   localparam logic signed [AW:0] FULL_S  = (AW + 1)'(tdrt_pkg::FULL_TURN);
   localparam logic [AW-1:0]      FULL_U  = AW'(tdrt_pkg::FULL_TURN);

   logic [1:0]                 state_ff, state_in;
   logic [IW-1:0]              iter_ff, iter_in;
   logic signed [CW-1:0]       x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]       z_ff, z_in;
   tdrt_pkg::flags_type        flags_ff;
   logic [AW-1:0]              angle_ff, angle_in;
   logic [AW-1:0]              prev_ff, prev_in;
   logic                       was_ff, was_in;
   logic signed [TOTAL_BITS-1:0] total_ff, total_in;
   logic                       out_valid_ff, out_valid_in;
   logic [tdrt_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic                       out_free, load;
   logic signed [CW-1:0]       x_sh, y_sh;
   logic signed [ZW-1:0]       atan_term;

   assign out_free  = !out_valid_ff || out_ready;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign load      = (state_ff == ST_EMIT) && out_free;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   assign x_sh      = x_ff >>> iter_ff;
   assign y_sh      = y_ff >>> iter_ff;
   assign atan_term = $signed(ZW'(tdrt_pkg::ATAN_Q16[iter_ff]));

   // sequencer and cordic iterations
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               iter_in = '0;
               x_in    = $signed(CW'(q_big) << tdrt_pkg::CORDIC_PRESHIFT);
               y_in    = $signed(CW'(q_small) << tdrt_pkg::CORDIC_PRESHIFT);
               unique case (q_flags.kind)
                  tdrt_pkg::KIND_DIAG: begin
                     z_in     = tdrt_pkg::DEG45_Q;
                     state_in = ST_ANGLE;
                  end
                  tdrt_pkg::KIND_CORDIC: begin
                     z_in     = '0;
                     state_in = ST_RUN;
                  end
                  default: begin
                     z_in     = '0;
                     state_in = ST_ANGLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (y_ff > 0) begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_term;
            end else begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_term;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(tdrt_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // clamp, unfold to a full turn and truncate to whole degrees
   always_comb begin
      logic signed [ZW-1:0] a, t, mag;
      logic [AW-1:0]        whole;
      a = z_ff;
      if (z_ff < 0) begin
         a = '0;
      end else if (z_ff > tdrt_pkg::DEG45_Q) begin
         a = tdrt_pkg::DEG45_Q;
      end
      t = flags_ff.swapped ? (tdrt_pkg::DEG90_Q - a) : a;
      if (flags_ff.neg_x) begin
         t = tdrt_pkg::DEG180_Q - t;
      end
      if (flags_ff.neg_y) begin
         t = -t;
      end
      mag   = t[ZW-1] ? (-t) : t;
      whole = mag[FB+AW-1:FB];
      angle_in = (t[ZW-1] && whole != '0) ? (FULL_U - whole) : whole;
   end

   // step wrap and saturating total
   always_comb begin
      logic [AW-1:0]               prev_eff;
      logic signed [AW:0]          diff;
      logic signed [SW-1:0]        step;
      logic signed [TOTAL_BITS:0]  sum;
      logic signed [tdrt_pkg::VALUE_W-1:0] value;
      prev_eff = was_ff ? prev_ff : angle_ff;
      diff = $signed({1'b0, angle_ff}) - $signed({1'b0, prev_eff});
      if (diff > HALF_S) begin
         diff = diff - FULL_S;
      end else if (diff < -HALF_S) begin
         diff = diff + FULL_S;
      end
      step = flags_ff.touching ? diff[SW-1:0] : '0;
      sum  = (TOTAL_BITS + 1)'(total_ff) + (TOTAL_BITS + 1)'(step);
      prev_in  = prev_ff;
      was_in   = was_ff;
      total_in = total_ff;
      if (load) begin
         was_in = flags_ff.touching;
         if (flags_ff.touching) begin
            prev_in = angle_ff;
            unique case (sum[TOTAL_BITS:TOTAL_BITS-1])
               2'b01:   total_in = {1'b0, {(TOTAL_BITS - 1){1'b1}}};
               2'b10:   total_in = {1'b1, {(TOTAL_BITS - 1){1'b0}}};
               default: total_in = sum[TOTAL_BITS-1:0];
            endcase
         end
      end
      value = report_mode ? tdrt_pkg::VALUE_W'(step) : tdrt_pkg::VALUE_W'(total_in);
      out_data_in = {{PAD_W{1'b0}}, flags_ff.touching, angle_ff, step, value};
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         was_ff       <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         was_ff       <= was_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      if (q_pop) begin
         flags_ff <= q_flags;
      end
      if (state_ff == ST_ANGLE) begin
         angle_ff <= angle_in;
      end
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

>>> rtl/core/touch_dial_rotation_tracker.sv
// touch_dial_rotation_tracker: top level, configuration registers and the
// front end, queue and back end; depends on tdrt_pkg, tdrt_front, tdrt_queue, tdrt_back
//
//   channel  direction  payload (lowest bit first)
//   req_     in         touch_x, touch_y
//   rsp_     out        reported_value, step_degrees, current_angle, is_touching
//   csr_     in         write of centre_x, centre_y, report_mode by index
//
// an item whose offset needs the cordic passes through the back end in steps:
// a fetch, 16 iterations of the shared cordic stage, an unfold of the angle
// and an update of the total into the result register; on an axis, a diagonal
// or the centre it skips the iterations; the update waits while the result is stalled.
// synchronous reset clears the angle history, the total and all valid flags
// and loads the centre and mode registers with their defaults.
// the front end keeps taking items into the queue while the back end or
// the result register is stalled, until the queue is full.

module touch_dial_rotation_tracker #(
   parameter int COORD_BITS = tdrt_pkg::COORD_BITS_DEF,
   parameter int TOTAL_BITS = tdrt_pkg::TOTAL_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // touch_x, touch_y
   input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // reported_value, step_degrees, current_angle, is_touching
   output logic [tdrt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [tdrt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);

   localparam int QW = tdrt_pkg::FLAGS_W + 2 * COORD_BITS;

   logic [COORD_BITS-1:0] centre_x_ff, centre_x_in;
   logic [COORD_BITS-1:0] centre_y_ff, centre_y_in;
   logic                  mode_ff, mode_in;

   logic                  q_push, q_full, q_pop, q_empty;
   tdrt_pkg::flags_type   f_flags, b_flags;
   logic [COORD_BITS-1:0] f_big, f_small, b_big, b_small;
   logic [QW-1:0]         q_wdata, q_rdata;

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      mode_in     = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            tdrt_pkg::CSR_CENTRE_X:    centre_x_in = csr_wdata;
            tdrt_pkg::CSR_CENTRE_Y:    centre_y_in = csr_wdata;
            tdrt_pkg::CSR_REPORT_MODE: mode_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= COORD_BITS'(tdrt_pkg::CENTRE_X_RESET);
         centre_y_ff <= COORD_BITS'(tdrt_pkg::CENTRE_Y_RESET);
         mode_ff     <= 1'b0;
      end else begin
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         mode_ff     <= mode_in;
      end
   end

   tdrt_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .touch_x  (req_tdata[COORD_BITS-1:0]),
      .touch_y  (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .centre_x (centre_x_ff),
      .centre_y (centre_y_ff),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_flags  (f_flags),
      .q_big    (f_big),
      .q_small  (f_small)
   );

   assign q_wdata = {f_flags, f_big, f_small};

   tdrt_queue #(
      .WIDTH (QW),
      .DEPTH (tdrt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {b_flags, b_big, b_small} = q_rdata;

   tdrt_back #(
      .COORD_BITS (COORD_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_flags     (b_flags),
      .q_big       (b_big),
      .q_small     (b_small),
      .report_mode (mode_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata)
   );

endmodule

>>> rtl/core/tdrt_checker.sv
// tdrt_checker: port-level checks on the result channel of the tracker
// depends on tdrt_pkg; bound to touch_dial_rotation_tracker below

module tdrt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tdrt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // no step without a touch
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[50] |-> rsp_tdata[40:32] == 9'd0)
      else $error("nonzero step while not touching");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[49:41] < 9'd360)
      else $error("angle out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[40:32]) >= -180) &&
                     ($signed(rsp_tdata[40:32]) <= 180))
      else $error("step out of range");

endmodule

bind touch_dial_rotation_tracker tdrt_checker u_tdrt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
